// ----- design/spct_pkg.sv -----
package spct_pkg;

	localparam int IDX_MAX_W = 6;

	localparam logic [2:0] ST_HIT     = 3'd0;
	localparam logic [2:0] ST_SAME    = 3'd1;
	localparam logic [2:0] ST_MISS    = 3'd2;
	localparam logic [2:0] ST_UPDATED = 3'd3;
	localparam logic [2:0] ST_ADDED   = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;

	localparam logic [1:0] MODE_SET     = 2'd1;
	localparam logic [1:0] MODE_SET_OVR = 2'd2;

	localparam logic [2:0] LVL_INCOMPAT  = 3'd0;
	localparam logic [2:0] LVL_EXCELLENT = 3'd4;
	localparam logic [7:0] SAME_SCORE    = 8'd100;

	// hit data rippling down the cell row
	typedef struct packed {
		logic                 found;
		logic [IDX_MAX_W-1:0] idx;
		logic [2:0]           lvl;
		logic [7:0]           scr;
		logic [63:0]          ovr;
	} spct_hit_t;

	// key and write command broadcast to every cell
	typedef struct packed {
		logic [3:0]           mat_a;
		logic [3:0]           mat_b;
		logic                 wr_en;
		logic [IDX_MAX_W-1:0] slot;
		logic                 set_pair;
		logic [2:0]           lvl;
		logic [7:0]           scr;
		logic                 set_ovr;
		logic                 clr_ovr;
		logic [63:0]          ovr;
	} spct_cmd_t;

endpackage

// ----- design/spct_cell.sv -----
module spct_cell #(
	parameter int CELL_ID = 0
) (
	input  logic              clk,
	input  logic              valid,
	input  spct_pkg::spct_cmd_t cmd,
	input  spct_pkg::spct_hit_t hit_in,
	output spct_pkg::spct_hit_t hit_out
);

	logic [3:0]  mat_a_q, mat_b_q;
	logic [2:0]  lvl_q;
	logic [7:0]  scr_q;
	logic        flag_q;
	logic [63:0] ovr_q;
	logic        match;
	logic        sel;

	assign match = valid && ((mat_a_q == cmd.mat_a && mat_b_q == cmd.mat_b) ||
		(mat_a_q == cmd.mat_b && mat_b_q == cmd.mat_a));
	assign sel = cmd.wr_en && (cmd.slot == spct_pkg::IDX_MAX_W'(CELL_ID));

	always_comb begin
		hit_out = hit_in;
		if (!hit_in.found && match) begin
			hit_out.found = 1'b1;
			hit_out.idx   = spct_pkg::IDX_MAX_W'(CELL_ID);
			hit_out.lvl   = lvl_q;
			hit_out.scr   = scr_q;
			hit_out.ovr   = flag_q ? ovr_q : 64'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			lvl_q <= cmd.lvl;
			scr_q <= cmd.scr;
			if (cmd.set_pair) begin
				mat_a_q <= cmd.mat_a;
				mat_b_q <= cmd.mat_b;
			end
			if (cmd.set_ovr) begin
				flag_q <= 1'b1;
				ovr_q  <= cmd.ovr;
			end else if (cmd.clr_ovr) begin
				flag_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/symmetric_pair_compat_table.sv -----
// Latency: one item in, its result registered on the master side the next cycle.
// Throughput: one item per cycle while the result is taken; a held result stalls input.
// The hit search ripples combinationally through the row of entry cells.
// Reset (arst_n low, asynchronous): entry count and level tallies go to zero,
// output holds no item; entry contents are not cleared.
module symmetric_pair_compat_table #(
	parameter int TABLE_ENTRIES = 16,
	parameter int MATERIAL_BITS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// mode[1:0], material_a[5:2], material_b[9:6], new_level[12:10],
	// new_score[20:13], new_splice_temp[36:21], new_hold_ms[52:37],
	// new_compression[68:53], new_cool_ms[84:69], zero pad [87:85]
	input  logic [87:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], entry_index[6:3], level[9:7], score[17:10], can_splice[18],
	// splice_temp[34:19], hold_ms[50:35], compression[66:51], cool_ms[82:67],
	// entry_count[87:83], incompatible_count[92:88], excellent_count[97:93],
	// zero pad [103:98]
	output logic [103:0] m_tdata
);

	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int MB    = (MATERIAL_BITS < 4) ? MATERIAL_BITS : 4;
	localparam logic [3:0] MAT_MASK = 4'((9'd1 << MB) - 9'd1);

	logic [CNT_W-1:0] count_q, incompat_q, excel_q;
	logic [CNT_W-1:0] count_d, incompat_d, excel_d;
	logic             out_valid_q;
	logic [97:0]      out_q;
	logic             accept;

	logic [1:0]  mode;
	logic [3:0]  mat_a, mat_b;
	logic [2:0]  nl_raw, nl;
	logic [7:0]  ns;
	logic        is_set;

	spct_pkg::spct_cmd_t cmd;
	spct_pkg::spct_hit_t chain [TABLE_ENTRIES+1];
	spct_pkg::spct_hit_t hit;

	logic [2:0]  status;
	logic [3:0]  idx_out;
	logic [2:0]  lvl_out;
	logic [7:0]  scr_out;
	logic [63:0] ovr_out;
	logic        can_splice;
	logic        room;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q};

	assign mode   = s_tdata[1:0];
	assign mat_a  = s_tdata[5:2] & MAT_MASK;
	assign mat_b  = s_tdata[9:6] & MAT_MASK;
	assign nl_raw = s_tdata[12:10];
	assign nl     = (nl_raw > spct_pkg::LVL_EXCELLENT) ? spct_pkg::LVL_EXCELLENT : nl_raw;
	assign ns     = s_tdata[20:13];
	assign is_set = (mode == spct_pkg::MODE_SET) || (mode == spct_pkg::MODE_SET_OVR);
	assign room   = count_q < CNT_W'(TABLE_ENTRIES);

	// row of entry cells; the first matching cell claims the chain
	assign chain[0] = '0;
	genvar g;
	generate
		for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
			spct_cell #(.CELL_ID(g)) u_cell (
				.clk     (clk),
				.valid   (CNT_W'(g) < count_q),
				.cmd     (cmd),
				.hit_in  (chain[g]),
				.hit_out (chain[g+1])
			);
		end
	endgenerate
	assign hit = chain[TABLE_ENTRIES];

	always_comb begin
		cmd          = '0;
		cmd.mat_a    = mat_a;
		cmd.mat_b    = mat_b;
		cmd.lvl      = nl;
		cmd.scr      = ns;
		cmd.ovr      = s_tdata[84:21];
		cmd.set_ovr  = (mode == spct_pkg::MODE_SET_OVR);
		cmd.clr_ovr  = 1'b1;
		cmd.set_pair = !hit.found;
		cmd.slot     = hit.found ? hit.idx : spct_pkg::IDX_MAX_W'(count_q);
		cmd.wr_en    = accept && is_set && (hit.found || room);
		// a mode 1 update keeps the existing overrides
		if (hit.found) cmd.clr_ovr = 1'b0;

		status     = spct_pkg::ST_MISS;
		idx_out    = 4'd0;
		lvl_out    = 3'd0;
		scr_out    = 8'd0;
		ovr_out    = 64'd0;
		count_d    = count_q;
		incompat_d = incompat_q;
		excel_d    = excel_q;
		if (is_set) begin
			if (hit.found) begin
				status  = spct_pkg::ST_UPDATED;
				idx_out = 4'(hit.idx);
				incompat_d = incompat_q
					- CNT_W'(hit.lvl == spct_pkg::LVL_INCOMPAT)
					+ CNT_W'(nl == spct_pkg::LVL_INCOMPAT);
				excel_d = excel_q
					- CNT_W'(hit.lvl == spct_pkg::LVL_EXCELLENT)
					+ CNT_W'(nl == spct_pkg::LVL_EXCELLENT);
			end else if (room) begin
				status     = spct_pkg::ST_ADDED;
				idx_out    = 4'(count_q);
				count_d    = count_q + CNT_W'(1);
				incompat_d = incompat_q + CNT_W'(nl == spct_pkg::LVL_INCOMPAT);
				excel_d    = excel_q + CNT_W'(nl == spct_pkg::LVL_EXCELLENT);
			end else begin
				status = spct_pkg::ST_FULL;
			end
		end else if (hit.found) begin
			status  = spct_pkg::ST_HIT;
			idx_out = 4'(hit.idx);
			lvl_out = hit.lvl;
			scr_out = hit.scr;
			ovr_out = hit.ovr;
		end else if (mat_a == mat_b) begin
			status  = spct_pkg::ST_SAME;
			lvl_out = spct_pkg::LVL_EXCELLENT;
			scr_out = spct_pkg::SAME_SCORE;
		end
		can_splice = (status == spct_pkg::ST_HIT || status == spct_pkg::ST_SAME) &&
			(lvl_out != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			incompat_q  <= '0;
			excel_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_d;
				incompat_q <= incompat_d;
				excel_q    <= excel_d;
			end
			if (accept) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= {5'(excel_d), 5'(incompat_d), 5'(count_d), ovr_out,
				can_splice, scr_out, lvl_out, idx_out, status};
		end
	end

endmodule

// ----- design/spct_checker.sv -----
module spct_checker #(
	parameter int TABLE_ENTRIES = 16
) (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata
);

	logic [2:0] st;
	logic [4:0] cnt, inc, exc;
	assign st  = m_tdata[2:0];
	assign cnt = m_tdata[87:83];
	assign inc = m_tdata[92:88];
	assign exc = m_tdata[97:93];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_tally: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (6'(inc) + 6'(exc)) <= 6'(cnt))
		else $error("level tallies exceed entry count");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == spct_pkg::ST_FULL |-> cnt == 5'(TABLE_ENTRIES)
			&& m_tdata[6:3] == 4'd0)
		else $error("full reported with room left");

	a_added: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == spct_pkg::ST_ADDED |-> 4'(cnt - 5'd1) == m_tdata[6:3])
		else $error("added index not at end of table");

endmodule

bind symmetric_pair_compat_table spct_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_spct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
